// ===== design/lsfs_pkg.sv =====
`timescale 1ns / 1ps

package lsfs_pkg;

    // Operation codes carried on func
    typedef enum logic [1:0] {
        FUNC_SET_PIXEL = 2'd0,
        FUNC_FILL      = 2'd1,
        FUNC_START     = 2'd2,
        FUNC_TICK      = 2'd3
    } func_t;

    localparam int CHAN_W = 7;
    localparam int ROW_W  = 3 * CHAN_W;

    localparam logic [7:0] CHAN_MARK  = 8'h80;
    localparam logic [7:0] LATCH_BYTE = 8'h00;
    localparam logic [6:0] CHAN_MASK  = 7'h7F;

    // Channel index within a stored row {green, red, blue}
    typedef enum logic [1:0] {
        CH_GREEN = 2'd0,
        CH_RED   = 2'd1,
        CH_BLUE  = 2'd2
    } chan_t;

    // Odd entries of the 256-entry strip gamma curve, halved
    localparam logic [6:0] GAMMA7 [128] = '{
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
        7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd1,   7'd1,   7'd1,
        7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,   7'd1,
        7'd1,   7'd1,   7'd1,   7'd2,   7'd2,   7'd2,   7'd2,   7'd2,
        7'd2,   7'd2,   7'd2,   7'd3,   7'd3,   7'd3,   7'd3,   7'd3,
        7'd3,   7'd4,   7'd4,   7'd4,   7'd4,   7'd4,   7'd5,   7'd5,
        7'd5,   7'd5,   7'd6,   7'd6,   7'd6,   7'd7,   7'd7,   7'd7,
        7'd8,   7'd8,   7'd8,   7'd9,   7'd9,   7'd10,  7'd10,  7'd10,
        7'd11,  7'd11,  7'd12,  7'd13,  7'd13,  7'd14,  7'd14,  7'd15,
        7'd16,  7'd17,  7'd17,  7'd18,  7'd19,  7'd20,  7'd21,  7'd22,
        7'd23,  7'd24,  7'd25,  7'd26,  7'd27,  7'd28,  7'd30,  7'd31,
        7'd32,  7'd34,  7'd36,  7'd37,  7'd39,  7'd41,  7'd42,  7'd44,
        7'd46,  7'd48,  7'd51,  7'd53,  7'd55,  7'd58,  7'd60,  7'd63,
        7'd66,  7'd69,  7'd72,  7'd75,  7'd79,  7'd82,  7'd86,  7'd90,
        7'd94,  7'd98,  7'd102, 7'd107, 7'd112, 7'd117, 7'd122, 7'd127
    };

    function automatic logic [6:0] chan_fix(input logic [7:0] raw, input logic gamma_on);
        logic [6:0] v;
        v = raw[6:0] & CHAN_MASK;
        return gamma_on ? GAMMA7[v] : v;
    endfunction

endpackage

// ===== design/lsfs_ram.sv =====
`timescale 1ns / 1ps

module lsfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/led_strip_frame_streamer_top.sv =====
`timescale 1ns / 1ps

// LED strip frame streamer.
// Input channel (in_valid/in_ready) takes one command beat: func selects set pixel,
// fill, start frame or tick; pixel_index and color carry the pixel and its GRB value.
// Output channel (out_valid/out_ready) returns one beat per tick of a running frame:
// the stored channel with bit 7 set, then FLUSH_BYTES zero latch bytes. frame_first
// marks the first byte, frame_last the final latch byte. cfg_wr_en/cfg_wr_data write
// use_gamma, which applies to later pixel writes only.
// A tick for a channel byte reads the frame store, and the read data is then loaded
// into the output register; a latch byte is registered and shows the cycle after acceptance.
// Set pixel, start and latch ticks do not hold in_ready low by themselves; a channel
// tick holds it low through the registered frame-store read, and fill holds it low
// while it writes one store row per cycle. Items during a frame other than ticks are dropped.
// Reset: the frame store is cleared by a pass over all PIXELS rows, one row per cycle,
// during which in_ready stays low. dirty, sending and use_gamma clear.
// Stall: a beat waiting on out_ready holds; in_ready stays low until it is taken
// or is taken in the same cycle, so no result is lost.
module led_strip_frame_streamer_top
    import lsfs_pkg::*;
#(
    parameter int PIXELS      = 32,
    parameter int FLUSH_BYTES = 1
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [9:0]  pixel_index,
    input  logic [23:0] color,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        frame_first,
    output logic        frame_last
);

    localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int FW = (FLUSH_BYTES > 1) ? $clog2(FLUSH_BYTES) : 1;
    localparam logic [AW-1:0] LAST_ROW   = AW'(PIXELS - 1);
    localparam logic [FW-1:0] LAST_FLUSH = FW'(FLUSH_BYTES - 1);
    localparam logic [10:0]   PIXELS_W   = 11'(PIXELS);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_FILL,
        S_READ
    } state_t;

    state_t            state_reg, state_next;
    logic              gamma_reg, gamma_next;
    logic              dirty_reg, dirty_next;
    logic              sending_reg, sending_next;
    logic              flushing_reg, flushing_next;
    logic [AW-1:0]     pix_reg, pix_next;
    chan_t             chan_reg, chan_next;
    logic [FW-1:0]     flush_reg, flush_next;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic [ROW_W-1:0]  fill_row_reg, fill_row_next;
    chan_t             rd_chan_reg, rd_chan_next;
    logic              rd_first_reg, rd_first_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_first_reg, out_first_next;
    logic              out_last_reg, out_last_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [ROW_W-1:0]  ram_rdata;

    logic              in_beat;
    logic [ROW_W-1:0]  color_row;
    logic [6:0]        rd_chan_val;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_beat   = in_valid && in_ready;
    assign color_row = {chan_fix(color[23:16], gamma_reg),
                        chan_fix(color[15:8], gamma_reg),
                        chan_fix(color[7:0], gamma_reg)};

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign frame_first = out_first_reg;
    assign frame_last  = out_last_reg;

    always_comb
    begin
        unique case (rd_chan_reg)
            CH_GREEN: rd_chan_val = ram_rdata[3*CHAN_W-1:2*CHAN_W];
            CH_RED:   rd_chan_val = ram_rdata[2*CHAN_W-1:CHAN_W];
            CH_BLUE:  rd_chan_val = ram_rdata[CHAN_W-1:0];
            default:  rd_chan_val = ram_rdata[CHAN_W-1:0];
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        gamma_next     = cfg_wr_en ? cfg_wr_data : gamma_reg;
        dirty_next     = dirty_reg;
        sending_next   = sending_reg;
        flushing_next  = flushing_reg;
        pix_next       = pix_reg;
        chan_next      = chan_reg;
        flush_next     = flush_reg;
        sweep_next     = sweep_reg;
        fill_row_next  = fill_row_reg;
        rd_chan_next   = rd_chan_reg;
        rd_first_next  = rd_first_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_first_next = out_first_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = sweep_reg;
        ram_wdata      = fill_row_reg;
        ram_re         = 1'b0;

        unique case (state_reg)
            S_CLEAR, S_FILL:
            begin
                // Write one row per cycle with the latched row value
                ram_we = 1'b1;
                if (sweep_reg == LAST_ROW)
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            S_READ:
            begin
                // Read data is back: load the output beat
                out_valid_next = 1'b1;
                out_byte_next  = CHAN_MARK | {1'b0, rd_chan_val};
                out_first_next = rd_first_reg;
                out_last_next  = 1'b0;
                state_next     = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_beat)
                begin
                    if (func_t'(func) == FUNC_TICK)
                    begin
                        if (sending_reg && !flushing_reg)
                        begin
                            ram_re        = 1'b1;
                            rd_chan_next  = chan_reg;
                            rd_first_next = (pix_reg == '0) && (chan_reg == CH_GREEN);
                            state_next    = S_READ;
                            if (chan_reg == CH_BLUE)
                            begin
                                chan_next = CH_GREEN;
                                if (pix_reg == LAST_ROW)
                                begin
                                    pix_next      = '0;
                                    flushing_next = 1'b1;
                                    flush_next    = '0;
                                end
                                else
                                begin
                                    pix_next = pix_reg + AW'(1);
                                end
                            end
                            else
                            begin
                                chan_next = (chan_reg == CH_GREEN) ? CH_RED : CH_BLUE;
                            end
                        end
                        else if (sending_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_byte_next  = LATCH_BYTE;
                            out_first_next = 1'b0;
                            out_last_next  = (flush_reg == LAST_FLUSH);
                            if (flush_reg == LAST_FLUSH)
                            begin
                                // Frame done: drop sending and dirty
                                sending_next  = 1'b0;
                                flushing_next = 1'b0;
                                dirty_next    = 1'b0;
                                flush_next    = '0;
                            end
                            else
                            begin
                                flush_next = flush_reg + FW'(1);
                            end
                        end
                    end
                    else if (!sending_reg)
                    begin
                        unique case (func_t'(func))
                            FUNC_SET_PIXEL:
                            begin
                                if ({1'b0, pixel_index} < PIXELS_W)
                                begin
                                    ram_we     = 1'b1;
                                    ram_waddr  = AW'(pixel_index);
                                    ram_wdata  = color_row;
                                    dirty_next = 1'b1;
                                end
                            end
                            FUNC_FILL:
                            begin
                                fill_row_next = color_row;
                                sweep_next    = '0;
                                dirty_next    = 1'b1;
                                state_next    = S_FILL;
                            end
                            FUNC_START:
                            begin
                                if (dirty_reg)
                                begin
                                    sending_next  = 1'b1;
                                    flushing_next = 1'b0;
                                    pix_next      = '0;
                                    chan_next     = CH_GREEN;
                                    flush_next    = '0;
                                end
                            end
                            default:
                            begin
                                // tick is handled above
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            gamma_reg     <= 1'b0;
            dirty_reg     <= 1'b0;
            sending_reg   <= 1'b0;
            flushing_reg  <= 1'b0;
            pix_reg       <= '0;
            chan_reg      <= CH_GREEN;
            flush_reg     <= '0;
            sweep_reg     <= '0;
            fill_row_reg  <= '0;
            rd_chan_reg   <= CH_GREEN;
            rd_first_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_first_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gamma_reg     <= gamma_next;
            dirty_reg     <= dirty_next;
            sending_reg   <= sending_next;
            flushing_reg  <= flushing_next;
            pix_reg       <= pix_next;
            chan_reg      <= chan_next;
            flush_reg     <= flush_next;
            sweep_reg     <= sweep_next;
            fill_row_reg  <= fill_row_next;
            rd_chan_reg   <= rd_chan_next;
            rd_first_reg  <= rd_first_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_first_reg <= out_first_next;
            out_last_reg  <= out_last_next;
        end
    end

    // Frame store: one row of {green, red, blue} per pixel
    lsfs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (PIXELS)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (pix_reg),
        .rd_data (ram_rdata)
    );

    a_read_loads_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> out_valid_reg)
        else $error("frame store read did not produce a beat");

    a_no_write_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !sending_reg)
        else $error("frame store written while a frame is running");

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (!sending_reg && !dirty_reg))
        else $error("last latch byte left the frame running");

    a_idle_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && (func == FUNC_TICK) && !sending_reg) |=> !out_valid_reg)
        else $error("tick outside a frame produced a beat");

    a_first_is_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_first_reg) |-> (out_byte_reg[7] && !out_last_reg))
        else $error("first beat of frame is not a channel byte");

endmodule
